// ===== design/tftpw_pkg.sv =====
package tftpw_pkg;

    localparam int LEN_W = 10;
    localparam int BLK_W = 16;
    localparam int OP_W  = 16;
    localparam int ST_W  = 3;
    localparam int TC_W  = 4;

    localparam logic [LEN_W-1:0] MAX_PACKET_BYTES = LEN_W'(516);
    localparam logic [LEN_W-1:0] WRQ_MIN_LEN      = LEN_W'(10);
    localparam logic [LEN_W-1:0] DATA_HDR_LEN     = LEN_W'(4);

    localparam logic [OP_W-1:0] OP_WRQ  = OP_W'(2);
    localparam logic [OP_W-1:0] OP_DATA = OP_W'(3);

    localparam logic [ST_W-1:0] ST_ONGOING     = 3'd0;
    localparam logic [ST_W-1:0] ST_SUCCESS     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_WRQ     = 3'd2;
    localparam logic [ST_W-1:0] ST_TIMEOUTS    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_DATA    = 3'd4;
    localparam logic [ST_W-1:0] ST_WRONG_BLOCK = 3'd5;

    localparam logic [TC_W-1:0] TC_MAX           = '1;
    localparam logic [TC_W-1:0] MAX_TIMEOUTS_RST = TC_W'(7);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             expiry;
        logic             wrq_ok;
        logic             data_ok;
        logic             full_size;
        logic [BLK_W-1:0] block_number;
        logic [LEN_W-1:0] length;
    } tftpw_item_t;

endpackage

// ===== design/tftpw_front.sv =====
module tftpw_front import tftpw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [OP_W-1:0]   s_opcode,
    input  logic [BLK_W-1:0]  s_block_number,
    input  logic [LEN_W-1:0]  s_packet_length,
    output logic              item_valid,
    input  logic              item_ready,
    output tftpw_item_t       item
);

    logic        valid_reg;
    tftpw_item_t item_reg;
    tftpw_item_t item_next;
    logic [LEN_W-1:0] len_sat;

    // clamp oversized lengths
    assign len_sat = (s_packet_length > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : s_packet_length;

    always_comb begin
        item_next.expiry       = s_kind;
        item_next.wrq_ok       = (s_opcode == OP_WRQ) && (len_sat >= WRQ_MIN_LEN);
        item_next.data_ok      = (s_opcode == OP_DATA) && (len_sat >= DATA_HDR_LEN);
        item_next.full_size    = (len_sat == MAX_PACKET_BYTES);
        item_next.block_number = s_block_number;
        item_next.length       = len_sat;
    end

    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== design/tftpw_queue.sv =====
module tftpw_queue import tftpw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  tftpw_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output tftpw_item_t out_item
);

    tftpw_item_t       store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== design/tftpw_back.sv =====
module tftpw_back import tftpw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [TC_W-1:0]   max_timeouts,
    input  logic              item_valid,
    output logic              item_ready,
    input  tftpw_item_t       item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_send_ack,
    output logic [BLK_W-1:0]  m_ack_block,
    output logic [LEN_W-1:0]  m_payload_bytes,
    output logic [ST_W-1:0]   m_status
);

    logic              in_transfer_reg, in_transfer_next;
    logic [BLK_W-1:0]  expected_block_reg, expected_block_next;
    logic [TC_W-1:0]   timeout_count_reg, timeout_count_next;

    logic              out_valid_reg;
    logic              ack_reg, ack_next;
    logic [BLK_W-1:0]  ack_block_reg, ack_block_next;
    logic [LEN_W-1:0]  payload_reg, payload_next;
    logic [ST_W-1:0]   status_reg, status_next;

    logic              take;
    logic [TC_W-1:0]   tc_inc;
    logic [BLK_W-1:0]  blk_inc;

    assign item_ready = !out_valid_reg || m_ready;
    assign take       = item_valid && item_ready;
    assign tc_inc     = (timeout_count_reg == TC_MAX) ? TC_MAX : timeout_count_reg + 1'b1;
    assign blk_inc    = expected_block_reg + 1'b1;

    always_comb begin
        in_transfer_next    = in_transfer_reg;
        expected_block_next = expected_block_reg;
        timeout_count_next  = timeout_count_reg;
        ack_next            = 1'b0;
        ack_block_next      = '0;
        payload_next        = '0;
        status_next         = ST_ONGOING;
        priority if (!in_transfer_reg) begin
            if (item.expiry) begin
                status_next = ST_ONGOING;
            end else if (item.wrq_ok) begin
                in_transfer_next    = 1'b1;
                expected_block_next = '0;
                timeout_count_next  = '0;
                ack_next            = 1'b1;
            end else begin
                status_next = ST_NOT_WRQ;
            end
        end else if (item.expiry) begin
            timeout_count_next = tc_inc;
            ack_next           = 1'b1;
            ack_block_next     = expected_block_reg;
            if (tc_inc >= max_timeouts) begin
                in_transfer_next = 1'b0;
                status_next      = ST_TIMEOUTS;
            end
        end else begin
            expected_block_next = blk_inc;
            priority if (!item.data_ok) begin
                in_transfer_next = 1'b0;
                status_next      = ST_NOT_DATA;
            end else if (item.block_number != blk_inc) begin
                in_transfer_next = 1'b0;
                status_next      = ST_WRONG_BLOCK;
            end else begin
                timeout_count_next = '0;
                ack_next           = 1'b1;
                ack_block_next     = blk_inc;
                payload_next       = item.length - DATA_HDR_LEN;
                if (!item.full_size) begin
                    in_transfer_next = 1'b0;
                    status_next      = ST_SUCCESS;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_transfer_reg    <= 1'b0;
            expected_block_reg <= '0;
            timeout_count_reg  <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (take) begin
                in_transfer_reg    <= in_transfer_next;
                expected_block_reg <= expected_block_next;
                timeout_count_reg  <= timeout_count_next;
            end
            if (item_ready) begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ack_reg       <= ack_next;
            ack_block_reg <= ack_block_next;
            payload_reg   <= payload_next;
            status_reg    <= status_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_send_ack      = ack_reg;
    assign m_ack_block     = ack_block_reg;
    assign m_payload_bytes = payload_reg;
    assign m_status        = status_reg;

    a_fail_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (status_next != ST_ONGOING) |=> !in_transfer_reg)
        else $error("transfer still open after final status");

    a_payload_acked: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (payload_reg != '0) |-> ack_reg && (status_reg == ST_ONGOING
            || status_reg == ST_SUCCESS))
        else $error("payload reported without acknowledgement");

    a_no_ack_zero_block: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !ack_reg |-> (ack_block_reg == '0) && (payload_reg == '0))
        else $error("block or payload set without acknowledgement");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !in_transfer_reg && !item.expiry && item.wrq_ok |=>
            in_transfer_reg && (expected_block_reg == '0) && (timeout_count_reg == '0))
        else $error("write request did not open a fresh transfer");

endmodule

// ===== design/tftp_write_receiver.sv =====
// Receiving side of a TFTP write transfer. Each item on s_ is a packet
// summary (s_kind 0) or a wait-period expiry (s_kind 1), and yields exactly
// one result item on m_. One item is taken every cycle when m_ready stays
// high; each result passes through the input register, the two-entry
// queue and the output register, and is held there while m_
// back-pressures. max_timeouts is written through cfg_valid/cfg_ready/
// cfg_data (always ready, reset value 7) and must only change while idle.
module tftp_write_receiver import tftpw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TC_W-1:0]   cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [OP_W-1:0]   s_opcode,
    input  logic [BLK_W-1:0]  s_block_number,
    input  logic [LEN_W-1:0]  s_packet_length,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_send_ack,
    output logic [BLK_W-1:0]  m_ack_block,
    output logic [LEN_W-1:0]  m_payload_bytes,
    output logic [ST_W-1:0]   m_status
);

    logic [TC_W-1:0] max_timeouts_reg;
    logic            f_valid, f_ready;
    tftpw_item_t     f_item;
    logic            q_valid, q_ready;
    tftpw_item_t     q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_timeouts_reg <= MAX_TIMEOUTS_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_timeouts_reg <= cfg_data;
        end
    end

    tftpw_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_opcode        (s_opcode),
        .s_block_number  (s_block_number),
        .s_packet_length (s_packet_length),
        .item_valid      (f_valid),
        .item_ready      (f_ready),
        .item            (f_item)
    );

    tftpw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    tftpw_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .max_timeouts    (max_timeouts_reg),
        .item_valid      (q_valid),
        .item_ready      (q_ready),
        .item            (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_ack      (m_send_ack),
        .m_ack_block     (m_ack_block),
        .m_payload_bytes (m_payload_bytes),
        .m_status        (m_status)
    );

endmodule
